FILE: sv/bcdec_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and arithmetic helpers of the BC1/BC2/BC3 block decoder.
// Used by every module of the decoder; depends on nothing.

package bcdec_pkg;

   // Default largest image dimension in pixels
   localparam int MAX_DIMENSION_DEF = 4096;

   // Fixed field widths
   localparam int CFG_DATA_W  = 13;
   localparam int CSR_INDEX_W = 2;
   localparam int PIX_W       = 12;
   localparam int BLK_POS_W   = PIX_W - 2;
   localparam int CHAN_W      = 8;
   localparam int QUEUE_DEPTH = 2;

   // Block format codes
   localparam logic [1:0] FMT_DXT1 = 2'd0;
   localparam logic [1:0] FMT_DXT3 = 2'd1;
   localparam logic [1:0] FMT_DXT5 = 2'd2;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_FORMAT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WIDTH  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEIGHT = 2'd2;

   // Register reset values
   localparam logic [CFG_DATA_W-1:0] DIM_RESET = 13'd256;

   // Compressed block as it arrives
   typedef struct packed {
      logic [63:0] alpha_word;
      logic [63:0] color_word;
   } req_type;

   // One decoded texel
   typedef struct packed {
      logic [PIX_W-1:0]  pixel_x;
      logic [PIX_W-1:0]  pixel_y;
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] alpha;
      logic              block_done;
      logic              image_done;
   } rsp_type;

   // Configuration registers as seen by the front end
   typedef struct packed {
      logic [1:0]            block_format;
      logic [CFG_DATA_W-1:0] image_width;
      logic [CFG_DATA_W-1:0] image_height;
   } cfg_type;

   // Color triple: [2] red, [1] green, [0] blue
   typedef logic [2:0][CHAN_W-1:0] rgb_type;

   // Classified block handed from front end to back end
   typedef struct packed {
      logic [1:0]                 fmt;
      logic                       four;
      rgb_type [3:0]              pal;
      logic [7:0][CHAN_W-1:0]     alpha_tab;
      logic [63:0]                alpha_word;
      logic [31:0]                color_idx;
      logic [BLK_POS_W-1:0]       blk_x;
      logic [BLK_POS_W-1:0]       blk_y;
      logic [1:0]                 last_x;
      logic [1:0]                 last_y;
      logic                       last_block;
   } entry_type;

   // 5-bit channel to 8 bits with rounding
   function automatic logic [7:0] widen5(input logic [4:0] v);
      logic [12:0] t;
      logic [12:0] s;
      t = 13'(v) * 13'd255 + 13'd16;
      s = 13'(t >> 5) + t;
      return s[12:5];
   endfunction

   // 6-bit channel to 8 bits with rounding
   function automatic logic [7:0] widen6(input logic [5:0] v);
      logic [13:0] t;
      logic [13:0] s;
      t = 14'(v) * 14'd255 + 14'd32;
      s = 14'(t >> 6) + t;
      return s[13:6];
   endfunction

   // x / 3 for x <= 765, reciprocal multiply
   function automatic logic [7:0] div3(input logic [9:0] x);
      logic [19:0] p;
      p = 20'(x) * 20'd683;
      return p[18:11];
   endfunction

   // x / 5 for x <= 1275
   function automatic logic [7:0] div5(input logic [10:0] x);
      logic [23:0] p;
      p = 24'(x) * 24'd3277;
      return p[21:14];
   endfunction

   // x / 7 for x <= 1785
   function automatic logic [7:0] div7(input logic [10:0] x);
      logic [25:0] p;
      p = 26'(x) * 26'd4682;
      return p[22:15];
   endfunction

endpackage

FILE: sv/bcdec_front.sv
`timescale 1ns / 1ps
// Front end: accepts compressed blocks, tracks block position, builds palettes.
// Depends on bcdec_pkg.

module bcdec_front #(
   parameter int MAX_DIMENSION = bcdec_pkg::MAX_DIMENSION_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  bcdec_pkg::cfg_type   cfg,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  bcdec_pkg::req_type   req_data,
   output logic                 push_valid,
   input  logic                 push_ready,
   output bcdec_pkg::entry_type push_data
);

   localparam int DIM_W = $clog2(MAX_DIMENSION + 1);
   localparam int BLK_W = DIM_W - 1;
   localparam int CMP_W = (DIM_W > bcdec_pkg::CFG_DATA_W) ? DIM_W : bcdec_pkg::CFG_DATA_W;

   // clamped image size and block counts
   logic [CMP_W-1:0] w_raw, h_raw;
   logic [DIM_W-1:0] img_w, img_h;
   logic [BLK_W-1:0] blk_cnt_x, blk_cnt_y;

   // block position state
   logic [BLK_W-1:0] col_ff, row_ff, col_in, row_in;
   logic [BLK_W-1:0] cur_col, cur_row, row_step, col_step, row_next;
   logic             wrap_col, cur_last;

   // stage A
   logic                 a_valid_ff;
   bcdec_pkg::req_type   a_req_ff;
   logic [BLK_W-1:0]     a_col_ff, a_row_ff;
   logic                 a_last_ff;

   // stage B
   logic                          b_valid_ff;
   bcdec_pkg::rgb_type            b_e0_ff, b_e1_ff;
   logic                          b_four_ff;
   logic [1:0]                    b_fmt_ff;
   logic [7:0][7:0]               b_alpha_tab_ff;
   logic [63:0]                   b_alpha_word_ff;
   logic [31:0]                   b_color_idx_ff;
   logic [bcdec_pkg::BLK_POS_W-1:0] b_blk_x_ff, b_blk_y_ff;
   logic [1:0]                    b_last_x_ff, b_last_y_ff;
   logic                          b_last_block_ff;

   // A to B combinational results
   logic [15:0]        c0_w, c1_w;
   bcdec_pkg::rgb_type e0_w, e1_w;
   logic               four_w;
   logic [7:0]         a0_w, a1_w;
   logic [7:0][7:0]    alpha_tab_w;
   logic [DIM_W:0]     px_base, py_base, rem_x, rem_y;
   logic [1:0]         last_x_w, last_y_w;

   // B to queue palette
   bcdec_pkg::rgb_type [3:0] pal_w;

   logic a_free, b_free, a_take, a_move;

   // clamp dimensions to [1, MAX_DIMENSION]
   always_comb begin
      w_raw = CMP_W'(cfg.image_width);
      h_raw = CMP_W'(cfg.image_height);
      if (w_raw == '0) begin
         img_w = DIM_W'(1);
      end else if (w_raw > CMP_W'(MAX_DIMENSION)) begin
         img_w = DIM_W'(MAX_DIMENSION);
      end else begin
         img_w = DIM_W'(w_raw);
      end
      if (h_raw == '0) begin
         img_h = DIM_W'(1);
      end else if (h_raw > CMP_W'(MAX_DIMENSION)) begin
         img_h = DIM_W'(MAX_DIMENSION);
      end else begin
         img_h = DIM_W'(h_raw);
      end
      blk_cnt_x = BLK_W'(((DIM_W+1)'(img_w) + (DIM_W+1)'(3)) >> 2);
      blk_cnt_y = BLK_W'(((DIM_W+1)'(img_h) + (DIM_W+1)'(3)) >> 2);
   end

   // position of the incoming block and of the one after it
   always_comb begin
      wrap_col = (col_ff >= blk_cnt_x);
      cur_col  = wrap_col ? '0 : col_ff;
      row_step = wrap_col ? BLK_W'(row_ff + 1'b1) : row_ff;
      cur_row  = (row_step >= blk_cnt_y) ? '0 : row_step;
      cur_last = (cur_col == BLK_W'(blk_cnt_x - 1'b1))
              && (cur_row == BLK_W'(blk_cnt_y - 1'b1));
      col_step = BLK_W'(cur_col + 1'b1);
      row_next = BLK_W'(cur_row + 1'b1);
      if (col_step >= blk_cnt_x) begin
         col_in = '0;
         row_in = (row_next >= blk_cnt_y) ? '0 : row_next;
      end else begin
         col_in = col_step;
         row_in = cur_row;
      end
   end

   // pipeline handshake: each stage moves when the next one has room
   assign b_free    = !b_valid_ff || push_ready;
   assign a_free    = !a_valid_ff || b_free;
   assign a_move    = a_valid_ff && b_free;
   assign req_ready = a_free;
   assign a_take    = req_valid && a_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (a_take) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // stage A: capture item and its position
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_free) begin
         a_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (a_take) begin
         a_req_ff  <= req_data;
         a_col_ff  <= cur_col;
         a_row_ff  <= cur_row;
         a_last_ff <= cur_last;
      end
   end

   // endpoints, color mode, alpha table, edge clipping
   always_comb begin
      c0_w   = a_req_ff.color_word[15:0];
      c1_w   = a_req_ff.color_word[31:16];
      e0_w[2] = bcdec_pkg::widen5(c0_w[15:11]);
      e0_w[1] = bcdec_pkg::widen6(c0_w[10:5]);
      e0_w[0] = bcdec_pkg::widen5(c0_w[4:0]);
      e1_w[2] = bcdec_pkg::widen5(c1_w[15:11]);
      e1_w[1] = bcdec_pkg::widen6(c1_w[10:5]);
      e1_w[0] = bcdec_pkg::widen5(c1_w[4:0]);
      four_w = (cfg.block_format == bcdec_pkg::FMT_DXT3)
            || (cfg.block_format == bcdec_pkg::FMT_DXT5)
            || (c0_w > c1_w);

      // DXT5: eight-entry mode when a0 > a1, else six entries plus 0 and 255
      a0_w = a_req_ff.alpha_word[7:0];
      a1_w = a_req_ff.alpha_word[15:8];
      alpha_tab_w[0] = a0_w;
      alpha_tab_w[1] = a1_w;
      for (int k = 2; k < 8; k++) begin
         if (a0_w > a1_w) begin
            alpha_tab_w[k] = bcdec_pkg::div7(11'(a0_w) * 11'(8 - k) + 11'(a1_w) * 11'(k - 1));
         end else if (k == 6) begin
            alpha_tab_w[k] = 8'h00;
         end else if (k == 7) begin
            alpha_tab_w[k] = 8'hFF;
         end else begin
            alpha_tab_w[k] = bcdec_pkg::div5(11'(a0_w) * 11'(6 - k) + 11'(a1_w) * 11'(k - 1));
         end
      end

      // last texel column and row still inside the image
      px_base = {a_col_ff, 2'b00};
      py_base = {a_row_ff, 2'b00};
      rem_x   = (DIM_W+1)'(img_w) - (DIM_W+1)'(1) - px_base;
      rem_y   = (DIM_W+1)'(img_h) - (DIM_W+1)'(1) - py_base;
      last_x_w = (rem_x >= (DIM_W+1)'(3)) ? 2'd3 : rem_x[1:0];
      last_y_w = (rem_y >= (DIM_W+1)'(3)) ? 2'd3 : rem_y[1:0];
   end

   // stage B
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_free) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_move) begin
         b_e0_ff         <= e0_w;
         b_e1_ff         <= e1_w;
         b_four_ff       <= four_w;
         b_fmt_ff        <= cfg.block_format;
         b_alpha_tab_ff  <= alpha_tab_w;
         b_alpha_word_ff <= a_req_ff.alpha_word;
         b_color_idx_ff  <= a_req_ff.color_word[63:32];
         b_blk_x_ff      <= bcdec_pkg::BLK_POS_W'(a_col_ff);
         b_blk_y_ff      <= bcdec_pkg::BLK_POS_W'(a_row_ff);
         b_last_x_ff     <= last_x_w;
         b_last_y_ff     <= last_y_w;
         b_last_block_ff <= a_last_ff;
      end
   end

   // color palette: thirds in four-color mode, mean and black otherwise
   always_comb begin
      pal_w[0] = b_e0_ff;
      pal_w[1] = b_e1_ff;
      for (int ch = 0; ch < 3; ch++) begin
         if (b_four_ff) begin
            pal_w[2][ch] = bcdec_pkg::div3({1'b0, b_e0_ff[ch], 1'b0} + 10'(b_e1_ff[ch]));
            pal_w[3][ch] = bcdec_pkg::div3(10'(b_e0_ff[ch]) + {1'b0, b_e1_ff[ch], 1'b0});
         end else begin
            pal_w[2][ch] = 8'((9'(b_e0_ff[ch]) + 9'(b_e1_ff[ch])) >> 1);
            pal_w[3][ch] = 8'h00;
         end
      end
   end

   assign push_valid = b_valid_ff;

   always_comb begin
      push_data.fmt        = b_fmt_ff;
      push_data.four       = b_four_ff;
      push_data.pal        = pal_w;
      push_data.alpha_tab  = b_alpha_tab_ff;
      push_data.alpha_word = b_alpha_word_ff;
      push_data.color_idx  = b_color_idx_ff;
      push_data.blk_x      = b_blk_x_ff;
      push_data.blk_y      = b_blk_y_ff;
      push_data.last_x     = b_last_x_ff;
      push_data.last_y     = b_last_y_ff;
      push_data.last_block = b_last_block_ff;
   end

endmodule

FILE: sv/bcdec_queue.sv
`timescale 1ns / 1ps
// Short queue of classified blocks between front end and back end.
// Depends on bcdec_pkg.

module bcdec_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  bcdec_pkg::entry_type push_data,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output bcdec_pkg::entry_type pop_data
);

   localparam int DEPTH = bcdec_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   bcdec_pkg::entry_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_ff + 1'b1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_ff + 1'b1);
         end
         if (do_push && !do_pop) begin
            count_ff <= CNT_W'(count_ff + 1'b1);
         end else if (do_pop && !do_push) begin
            count_ff <= CNT_W'(count_ff - 1'b1);
         end
      end
   end

endmodule

FILE: sv/bcdec_back.sv
`timescale 1ns / 1ps
// Back end: walks the texels of a block in raster order up to its last kept one and emits the kept ones.
// Depends on bcdec_pkg.

module bcdec_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 pop_valid,
   output logic                 pop_ready,
   input  bcdec_pkg::entry_type pop_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output bcdec_pkg::rsp_type   rsp_data
);

   bcdec_pkg::entry_type cur_ff;
   logic                 cur_valid_ff;
   logic [3:0]           tex_ff;
   bcdec_pkg::rsp_type   out_ff;
   logic                 out_valid_ff;

   logic [1:0]         xx, yy, cidx;
   logic [4:0]         cidx_off;
   logic [5:0]         nib_off, k_off;
   logic [3:0]         nib;
   logic [2:0]         k;
   logic [7:0]         alpha_w;
   bcdec_pkg::rgb_type rgb_w;
   logic               kept, done_tex, out_free, step, finishing, take;
   bcdec_pkg::rsp_type tex_data;

   // texel selection
   always_comb begin
      xx       = tex_ff[1:0];
      yy       = tex_ff[3:2];
      cidx_off = {tex_ff, 1'b0};
      cidx     = cur_ff.color_idx[cidx_off +: 2];
      nib_off  = {tex_ff, 2'b00};
      nib      = cur_ff.alpha_word[nib_off +: 4];
      k_off    = 6'd16 + {2'b00, tex_ff} + {1'b0, tex_ff, 1'b0};
      k        = cur_ff.alpha_word[k_off +: 3];
      rgb_w    = cur_ff.pal[cidx];
      kept     = (xx <= cur_ff.last_x) && (yy <= cur_ff.last_y);
      done_tex = (xx == cur_ff.last_x) && (yy == cur_ff.last_y);
   end

   // alpha by format
   always_comb begin
      unique case (cur_ff.fmt)
         bcdec_pkg::FMT_DXT3: alpha_w = {nib, nib};
         bcdec_pkg::FMT_DXT5: alpha_w = cur_ff.alpha_tab[k];
         default:             alpha_w = (!cur_ff.four && cidx == 2'd3) ? 8'h00 : 8'hFF;
      endcase
   end

   always_comb begin
      tex_data.pixel_x    = {cur_ff.blk_x, xx};
      tex_data.pixel_y    = {cur_ff.blk_y, yy};
      tex_data.red        = rgb_w[2];
      tex_data.green      = rgb_w[1];
      tex_data.blue       = rgb_w[0];
      tex_data.alpha      = alpha_w;
      tex_data.block_done = done_tex;
      tex_data.image_done = done_tex && cur_ff.last_block;
   end

   // one texel per cycle while the output register has room
   assign out_free  = !out_valid_ff || rsp_ready;
   assign step      = cur_valid_ff && out_free;
   assign finishing = step && done_tex;
   assign pop_ready = !cur_valid_ff || finishing;
   assign take      = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         tex_ff       <= '0;
      end else if (take) begin
         cur_valid_ff <= 1'b1;
         tex_ff       <= '0;
      end else if (finishing) begin
         cur_valid_ff <= 1'b0;
      end else if (step) begin
         tex_ff <= tex_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         cur_ff <= pop_data;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= step && kept;
      end
   end

   always_ff @(posedge clock) begin
      if (step && kept) begin
         out_ff <= tex_data;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

FILE: sv/bc1_bc2_bc3_texture_block_decoder.sv
`timescale 1ns / 1ps
// BC1/BC2/BC3 (DXT1/DXT3/DXT5) decoder: one compressed 4x4 block in, RGBA texels out.
// Top level; depends on bcdec_pkg, bcdec_front, bcdec_queue and bcdec_back.
//
// Each accepted item is one compressed block; blocks follow raster order and
// the decoder keeps the block position itself, wrapping at the end of the
// image (a register write does not reset it). Texels leave at most one per
// cycle while the output is not stalled, in raster order inside the block;
// those at or beyond the image width or height are not sent. The texel
// walker in the back end sets the rate: it holds a block until it reaches the
// last kept texel. The front end classifies a block in pipeline stages A and
// B, and a two-block queue sits between the two, so new blocks are taken while
// texels are still going out. A block passes stage A, stage B, the queue, the
// back end's block register and the output register. Write registers only
// while no block is in flight.

module bc1_bc2_bc3_texture_block_decoder #(
   parameter int MAX_DIMENSION = bcdec_pkg::MAX_DIMENSION_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  bcdec_pkg::req_type                     req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output bcdec_pkg::rsp_type                     rsp_data,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [bcdec_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [bcdec_pkg::CFG_DATA_W-1:0]       csr_data
);

   logic [1:0]                        fmt_ff;
   logic [bcdec_pkg::CFG_DATA_W-1:0]  width_ff, height_ff;
   bcdec_pkg::cfg_type                cfg;

   logic                 push_valid, push_ready, pop_valid, pop_ready;
   bcdec_pkg::entry_type push_data, pop_data;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff    <= bcdec_pkg::FMT_DXT1;
         width_ff  <= bcdec_pkg::DIM_RESET;
         height_ff <= bcdec_pkg::DIM_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            bcdec_pkg::CSR_FORMAT: fmt_ff    <= csr_data[1:0];
            bcdec_pkg::CSR_WIDTH:  width_ff  <= csr_data;
            bcdec_pkg::CSR_HEIGHT: height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.block_format = fmt_ff;
      cfg.image_width  = width_ff;
      cfg.image_height = height_ff;
   end

   bcdec_front #(
      .MAX_DIMENSION(MAX_DIMENSION)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   bcdec_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   bcdec_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: sim/tb_bc1_bc2_bc3_texture_block_decoder.sv
`timescale 1ns / 1ps
// Self-checking bench for the DXT1/DXT3/DXT5 block decoder: drives compressed blocks,
// predicts every decoded texel and compares each one. Depends on bcdec_pkg and the decoder.

module tb_bc1_bc2_bc3_texture_block_decoder;
   import bcdec_pkg::*;

   localparam int LIMIT = 400000;
   localparam int RANDOM_BLOCKS = 200;
   localparam int SETTLE = 12;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;
   localparam logic [1:0] FMT_SPARE = 2'd3;

   // Texel predictor: own copy of the registers and block position, queue of texels
   class texel_tracker;
      rsp_type pending_texels[$];
      logic [1:0] fmt;
      int unsigned width_reg, height_reg;
      int unsigned blk_col, blk_row;
      int mismatches;

      function new();
         fmt = FMT_DXT1;
         width_reg = DIM_RESET;
         height_reg = DIM_RESET;
         blk_col = 0;
         blk_row = 0;
         mismatches = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
         case (idx)
            CSR_FORMAT: fmt = val[1:0];
            CSR_WIDTH: width_reg = val;
            CSR_HEIGHT: height_reg = val;
            default: ;
         endcase
      endfunction

      function int unsigned clamp_dim(int unsigned v);
         if (v < 1) return 1;
         if (v > MAX_DIMENSION_DEF) return MAX_DIMENSION_DEF;
         return v;
      endfunction

      // n-bit channel to 8 bits, rounded
      function int unsigned widen(int unsigned v, int unsigned bits);
         int unsigned t;
         int unsigned scale;
         scale = 1 << bits;
         t = v * 255 + scale / 2;
         return (t / scale + t) / scale;
      endfunction

      function int pending();
         return pending_texels.size();
      endfunction

      // Works out the texels of one accepted block and queues them
      function void predict_block(req_type blk);
         int unsigned w, h, bx, by, c0, c1, c, idx, px, py, a, a0, a1, k;
         int unsigned pal[4][4];
         int unsigned ends[2][3];
         bit four, last_block;
         rsp_type kept[16];
         int n;
         w = clamp_dim(width_reg);
         h = clamp_dim(height_reg);
         bx = (w + 3) / 4;
         by = (h + 3) / 4;
         c0 = blk.color_word[15:0];
         c1 = blk.color_word[31:16];
         four = (fmt == FMT_DXT3) || (fmt == FMT_DXT5) || (c0 > c1);
         n = 0;

         // position may be stale after a register change
         if (blk_col >= bx) begin
            blk_col = 0;
            blk_row++;
         end
         if (blk_row >= by) blk_row = 0;
         last_block = (blk_col == bx - 1) && (blk_row == by - 1);

         // endpoints and palette
         for (int e = 0; e < 2; e++) begin
            c = (e == 0) ? c0 : c1;
            ends[e][0] = widen((c >> 11) & 'h1F, 5);
            ends[e][1] = widen((c >> 5) & 'h3F, 6);
            ends[e][2] = widen(c & 'h1F, 5);
         end
         for (int ch = 0; ch < 3; ch++) begin
            pal[0][ch] = ends[0][ch];
            pal[1][ch] = ends[1][ch];
            if (four) begin
               pal[2][ch] = (2 * ends[0][ch] + ends[1][ch]) / 3;
               pal[3][ch] = (ends[0][ch] + 2 * ends[1][ch]) / 3;
            end else begin
               pal[2][ch] = (ends[0][ch] + ends[1][ch]) / 2;
               pal[3][ch] = 0;
            end
         end
         pal[0][3] = 255;
         pal[1][3] = 255;
         pal[2][3] = 255;
         pal[3][3] = four ? 255 : 0;

         // texels in raster order, clipped to the image
         a0 = blk.alpha_word[7:0];
         a1 = blk.alpha_word[15:8];
         for (int i = 0; i < 16; i++) begin
            px = blk_col * 4 + (i % 4);
            py = blk_row * 4 + (i / 4);
            if (px >= w || py >= h) continue;
            idx = blk.color_word[32 + 2 * i +: 2];
            case (fmt)
               FMT_DXT3: a = blk.alpha_word[4 * i +: 4] * 17;
               FMT_DXT5: begin
                  k = blk.alpha_word[16 + 3 * i +: 3];
                  if (k == 0) a = a0;
                  else if (k == 1) a = a1;
                  else if (a0 > a1) a = ((8 - k) * a0 + (k - 1) * a1) / 7;
                  else if (k == 6) a = 0;
                  else if (k == 7) a = 255;
                  else a = ((6 - k) * a0 + (k - 1) * a1) / 5;
               end
               default: a = pal[idx][3];
            endcase
            kept[n].pixel_x = 12'(px);
            kept[n].pixel_y = 12'(py);
            kept[n].red = 8'(pal[idx][0]);
            kept[n].green = 8'(pal[idx][1]);
            kept[n].blue = 8'(pal[idx][2]);
            kept[n].alpha = 8'(a);
            kept[n].block_done = 1'b0;
            kept[n].image_done = 1'b0;
            n++;
         end
         if (n > 0) begin
            kept[n - 1].block_done = 1'b1;
            kept[n - 1].image_done = last_block;
         end
         for (int i = 0; i < n; i++) pending_texels.push_back(kept[i]);

         // advance the raster position
         blk_col++;
         if (blk_col >= bx) begin
            blk_col = 0;
            blk_row++;
            if (blk_row >= by) blk_row = 0;
         end
      endfunction

      task report(string msg);
         mismatches++;
         if (mismatches <= 40) $display("%0t ns: mismatch: %s", $time, msg);
      endtask

      task check_field(string name, int unsigned got_v, int unsigned want_v, rsp_type want);
         if (got_v != want_v)
            report($sformatf("texel (%0d,%0d) %s: got %0d, expected %0d",
                             want.pixel_x, want.pixel_y, name, got_v, want_v));
      endtask

      // Compares one received texel with the oldest queued one
      task check_texel(rsp_type got);
         rsp_type want;
         if (pending_texels.size() == 0) begin
            report($sformatf("texel (%0d,%0d) with nothing outstanding",
                             got.pixel_x, got.pixel_y));
            return;
         end
         want = pending_texels.pop_front();
         check_field("pixel_x", got.pixel_x, want.pixel_x, want);
         check_field("pixel_y", got.pixel_y, want.pixel_y, want);
         check_field("red", got.red, want.red, want);
         check_field("green", got.green, want.green, want);
         check_field("blue", got.blue, want.blue, want);
         check_field("alpha", got.alpha, want.alpha, want);
         check_field("block_done", got.block_done, want.block_done, want);
         check_field("image_done", got.image_done, want.image_done, want);
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   req_type req_data = '0;
   logic rsp_ready = 1'b0;
   logic csr_valid = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CFG_DATA_W-1:0] csr_data = '0;
   logic req_ready;
   logic rsp_valid;
   rsp_type rsp_data;
   logic csr_ready;

   bit calm = 1'b0;
   int unsigned cycles = 0;
   texel_tracker tracker = new();

   bc1_bc2_bc3_texture_block_decoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Idle length: mostly none or short, now and then long
   function automatic int pick_gap(int long_max);
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(6, long_max);
   endfunction

   // Image dimension: mostly small, sometimes zero, full size or over range
   function automatic logic [CFG_DATA_W-1:0] pick_dim();
      case ($urandom_range(0, 19))
         0: return '0;
         1: return CFG_DATA_W'(MAX_DIMENSION_DEF);
         2: return CFG_DATA_W'($urandom_range(MAX_DIMENSION_DEF + 1, 8191));
         3: return CFG_DATA_W'($urandom_range(25, 300));
         default: return CFG_DATA_W'($urandom_range(1, 24));
      endcase
   endfunction

   task automatic send_block(logic [63:0] aw, logic [63:0] cw);
      int gap;
      gap = pick_gap(30);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{alpha_word: aw, color_word: cw};
      do @(posedge clock); while (!req_ready);
      tracker.predict_block(req_data);
   endtask

   task automatic put_reg(logic [CSR_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      tracker.write_reg(idx, val);
   endtask

   // Wait until every texel is out, then let the pipeline settle
   task automatic drain();
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic configure(logic [1:0] fmt, logic [CFG_DATA_W-1:0] w,
                            logic [CFG_DATA_W-1:0] h, logic [2:0] which, bit spare);
      drain();
      if (which[0]) put_reg(CSR_FORMAT, CFG_DATA_W'(fmt));
      if (which[1]) put_reg(CSR_WIDTH, w);
      if (which[2]) put_reg(CSR_HEIGHT, h);
      if (spare) put_reg(CSR_SPARE, CFG_DATA_W'($urandom_range(0, 8191)));
      csr_valid <= 1'b0;
   endtask

   // Result side: check accepted texels, stall at random
   initial begin
      int stall;
      stall = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) tracker.check_texel(rsp_data);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            stall--;
         end else begin
            rsp_ready <= 1'b1;
            stall = pick_gap(20);
         end
      end
   end

   // Stimulus
   initial begin
      logic [47:0] ramp, fall;
      logic [63:0] aw, cw;
      int sent;
      int phase_len;
      for (int i = 0; i < 16; i++) begin
         ramp[3 * i +: 3] = 3'(i % 8);
         fall[3 * i +: 3] = 3'(7 - i % 8);
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // DXT1 at reset settings: equal, ordered and extreme endpoints
      send_block(64'h0, 64'h0);
      send_block('1, '1);
      send_block(64'h0, {32'hE4E4E4E4, 16'h0000, 16'hFFFF});
      send_block('1, {32'hE4E4E4E4, 16'hFFFF, 16'h0000});
      send_block(64'h0, {32'h1B1B1B1B, 16'h7BEF, 16'h7BEF});
      send_block(64'h0, {32'hFFAA5500, 16'h07E0, 16'hF800});

      // DXT3: explicit nibbles, four-color mode even with c0 < c1
      configure(FMT_DXT3, '0, '0, 3'b001, 1'b0);
      send_block(64'h0123456789ABCDEF, {32'hE4E4E4E4, 16'hFFFF, 16'h0000});
      send_block(64'hFEDCBA9876543210, {32'h1B1B1B1B, 16'hF81F, 16'h001F});

      // DXT5: eight-alpha and six-alpha ramps, equal alphas, all ones
      configure(FMT_DXT5, '0, '0, 3'b001, 1'b0);
      send_block({ramp, 8'h00, 8'hFF}, {32'hE4E4E4E4, 16'h0000, 16'hFFFF});
      send_block({ramp, 8'hFF, 8'h00}, {32'h1B1B1B1B, 16'hFFFF, 16'h0000});
      send_block({fall, 8'h80, 8'h80}, {32'hE4E4E4E4, 16'h1234, 16'h4321});
      send_block({fall, 8'hC8, 8'h25}, {32'hFFAA5500, 16'hF800, 16'h001F});
      send_block('1, '1);

      // unused format code decodes as DXT1
      configure(FMT_SPARE, '0, '0, 3'b001, 1'b0);
      send_block('1, {32'hE4E4E4E4, 16'hABCD, 16'h1234});
      send_block(64'h0, {32'hE4E4E4E4, 16'h0001, 16'hFFFF});

      // zero dimensions act as 1x1, position left beyond the image wraps
      configure(FMT_DXT1, '0, '0, 3'b111, 1'b1);
      send_block({$urandom, $urandom}, {$urandom, $urandom});
      send_block({$urandom, $urandom}, {$urandom, $urandom});

      // over-range dimensions clamp to the maximum
      configure(FMT_DXT3, 13'd8191, 13'd8191, 3'b111, 1'b0);
      send_block({$urandom, $urandom}, {$urandom, $urandom});
      send_block({$urandom, $urandom}, {$urandom, $urandom});

      configure(FMT_DXT5, 13'd4095, 13'd4097, 3'b111, 1'b0);
      send_block({$urandom, $urandom}, {$urandom, $urandom});
      send_block({$urandom, $urandom}, {$urandom, $urandom});

      // random phases, each with its own settings
      sent = 0;
      while (sent < RANDOM_BLOCKS) begin
         configure(2'($urandom_range(0, 3)), pick_dim(), pick_dim(),
                   3'($urandom_range(1, 7)), $urandom_range(0, 7) == 0);
         calm = ($urandom_range(0, 3) == 0);
         phase_len = $urandom_range(8, 30);
         repeat (phase_len) begin
            aw = {$urandom, $urandom};
            cw = {$urandom, $urandom};
            case ($urandom_range(0, 5))
               0: cw[31:16] = cw[15:0];
               1: aw[15:8] = aw[7:0];
               2: begin
                  cw[15] = 1'b1;
                  cw[31] = 1'b0;
               end
               3: begin
                  cw[15] = 1'b0;
                  cw[31] = 1'b1;
               end
               default: ;
            endcase
            send_block(aw, cw);
            sent++;
         end
      end

      drain();
      repeat (SETTLE) @(posedge clock);
      if (tracker.mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

FILE: files.f
sv/bcdec_pkg.sv
sv/bcdec_front.sv
sv/bcdec_queue.sv
sv/bcdec_back.sv
sv/bc1_bc2_bc3_texture_block_decoder.sv
sim/tb_bc1_bc2_bc3_texture_block_decoder.sv
